>>> hw/rtl/mfn_pkg.sv
// ----------------------------------------------------------------------------
// mfn_pkg: shared types and constants of the flood-fill maze navigator
// Direction, turn and register codes, datapath command codes and the
// command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package mfn_pkg;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd2;
  localparam logic [1:0] TURN_UTURN = 2'd3;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd4;

  localparam int DIST_W = 9;
  localparam logic [DIST_W-1:0] UNREACHED = 9'd511;
  localparam logic [DIST_W-1:0] DIST_MAX  = 9'd510;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam int DP_OP_W = 5;
  localparam logic [DP_OP_W-1:0] DP_NOP         = 5'd0;
  localparam logic [DP_OP_W-1:0] DP_SWEEP_WALL  = 5'd1;
  localparam logic [DP_OP_W-1:0] DP_SWEEP_DIST  = 5'd2;
  localparam logic [DP_OP_W-1:0] DP_CAPTURE     = 5'd3;
  localparam logic [DP_OP_W-1:0] DP_WC_RD       = 5'd4;
  localparam logic [DP_OP_W-1:0] DP_WC_WR       = 5'd5;
  localparam logic [DP_OP_W-1:0] DP_WN_RD       = 5'd6;
  localparam logic [DP_OP_W-1:0] DP_WN_WR       = 5'd7;
  localparam logic [DP_OP_W-1:0] DP_SEED        = 5'd8;
  localparam logic [DP_OP_W-1:0] DP_POP_RD      = 5'd9;
  localparam logic [DP_OP_W-1:0] DP_CELL_RD     = 5'd10;
  localparam logic [DP_OP_W-1:0] DP_CELL_LAT    = 5'd11;
  localparam logic [DP_OP_W-1:0] DP_NB_RD       = 5'd12;
  localparam logic [DP_OP_W-1:0] DP_NB_CHK      = 5'd13;
  localparam logic [DP_OP_W-1:0] DP_POP_DONE    = 5'd14;
  localparam logic [DP_OP_W-1:0] DP_SEL_RD      = 5'd15;
  localparam logic [DP_OP_W-1:0] DP_SEL_LAT     = 5'd16;
  localparam logic [DP_OP_W-1:0] DP_SN_RD       = 5'd17;
  localparam logic [DP_OP_W-1:0] DP_SN_CHK      = 5'd18;
  localparam logic [DP_OP_W-1:0] DP_DECIDE      = 5'd19;
  localparam logic [DP_OP_W-1:0] DP_RESTART_OUT = 5'd20;

  typedef struct packed {
    logic [DP_OP_W-1:0] op;
    logic [1:0]         dir;
  } cmd_t;

  typedef struct packed {
    logic       sweep_last;
    logic       queue_empty;
    logic       out_free;
    logic [3:0] wmask;
    logic [3:0] cur_nb_ok;
    logic [3:0] cell_open;
  } status_t;

  function automatic logic [1:0] scan_dir(logic [1:0] k);
    logic [1:0] d;
    unique case (k)
      2'd0: d = DIR_N;
      2'd1: d = DIR_S;
      2'd2: d = DIR_E;
      default: d = DIR_W;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/mfn_datapath.sv
// ----------------------------------------------------------------------------
// mfn_datapath: maps, queue, pose and result register of the navigator
// Executes one controller command per cycle against the wall, distance and
// queue memories, and holds the configuration and the pending result.
// ----------------------------------------------------------------------------
module mfn_datapath #(
  parameter int ROWS = 16,
  parameter int COLS = 16,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [mfn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [2:0]                     in_walls,
  input  logic                           m_tready,
  input  mfn_pkg::cmd_t                  cmd,
  output mfn_pkg::status_t               status,
  output logic                           m_tvalid,
  output logic [mfn_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int AW  = RW + CW;
  localparam int NC  = 1 << AW;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW  = mfn_pkg::DIST_W;

  function automatic logic [AW:0] nbr(logic [RW-1:0] r, logic [CW-1:0] c, logic [1:0] d);
    logic ok;
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    ok = 1'b0;
    nr = r;
    nc = c;
    unique case (d)
      mfn_pkg::DIR_N: if (int'(r) + 1 < ROWS) begin
        ok = 1'b1;
        nr = r + 1'b1;
      end
      mfn_pkg::DIR_E: if (int'(c) + 1 < COLS) begin
        ok = 1'b1;
        nc = c + 1'b1;
      end
      mfn_pkg::DIR_S: if (r != '0) begin
        ok = 1'b1;
        nr = r - 1'b1;
      end
      default: if (c != '0) begin
        ok = 1'b1;
        nc = c - 1'b1;
      end
    endcase
    return {ok, nr, nc};
  endfunction

  logic [3:0] goal_row, goal_col, home_row, home_col;
  logic [1:0] start_heading;

  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [1:0]    heading;
  logic [3:0]    wmask;
  logic [AW-1:0] sweep_cnt;
  logic [QW-1:0] head, tail;
  logic [CNW-1:0] count;
  logic [AW-1:0] pop_cell, ni;
  logic [DW-1:0] nd, cdist, best;
  logic [3:0]    cwall;
  logic [1:0]    tdir;
  logic [DW-1:0] ndist [4];

  logic [3:0]    wall_mem [NC];
  logic [DW-1:0] dist_mem [NC];
  logic [AW-1:0] queue_mem [QUEUE_DEPTH];
  logic [3:0]    wall_rd;
  logic [DW-1:0] dist_rd;
  logic [AW-1:0] queue_rd;

  logic [AW-1:0] wall_raddr, wall_waddr, dist_raddr, dist_waddr;
  logic [3:0]    wall_wdata;
  logic [DW-1:0] dist_wdata;
  logic          wall_we, dist_we, queue_we;
  logic [QW-1:0] queue_raddr, queue_waddr;
  logic [AW-1:0] queue_wdata;

  logic [AW:0]   cur_nb [4];
  logic [AW:0]   cell_nb [4];
  logic [AW:0]   mv_nb;
  logic [RW-1:0] srow;
  logic [CW-1:0] scol;
  logic          tgt_ok;
  logic [AW-1:0] tgt_cell;
  logic [AW-1:0] cur_cell;
  logic          mv;
  logic [1:0]    turn;

  logic          out_valid;
  logic [1:0]    out_turn;
  logic          out_moved;
  logic [3:0]    out_row, out_col;
  logic [1:0]    out_head;
  logic [DW-1:0] out_dist;

  assign srow = (int'(home_row) < ROWS) ? RW'(home_row) : RW'(ROWS - 1);
  assign scol = (int'(home_col) < COLS) ? CW'(home_col) : CW'(COLS - 1);
  assign tgt_ok = (int'(goal_row) < ROWS) && (int'(goal_col) < COLS);
  assign tgt_cell = {RW'(goal_row), CW'(goal_col)};
  assign cur_cell = {cur_row, cur_col};

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      cur_nb[d]  = nbr(cur_row, cur_col, 2'(d));
      cell_nb[d] = nbr(pop_cell[AW-1:CW], pop_cell[CW-1:0], 2'(d));
    end
  end

  assign mv_nb = nbr(cur_row, cur_col, tdir);
  assign mv = mv_nb[AW] && !cwall[tdir] && (cdist > ndist[tdir]);

  always_comb begin
    if (tdir == heading) turn = mfn_pkg::TURN_NONE;
    else if (tdir == heading + 2'd1) turn = mfn_pkg::TURN_RIGHT;
    else if (tdir == heading + 2'd3) turn = mfn_pkg::TURN_LEFT;
    else turn = mfn_pkg::TURN_UTURN;
  end

  always_comb begin
    status.sweep_last  = (sweep_cnt == AW'(NC - 1));
    status.queue_empty = (count == '0);
    status.out_free    = !out_valid || m_tready;
    status.wmask       = wmask;
    for (int d = 0; d < 4; d++) begin
      status.cur_nb_ok[d] = cur_nb[d][AW];
      status.cell_open[d] = cell_nb[d][AW] && !cwall[d];
    end
  end

  always_comb begin
    wall_raddr  = cur_cell;
    wall_waddr  = cur_cell;
    wall_wdata  = wall_rd | wmask;
    wall_we     = 1'b0;
    dist_raddr  = cur_cell;
    dist_waddr  = ni;
    dist_wdata  = nd;
    dist_we     = 1'b0;
    queue_raddr = head;
    queue_waddr = tail;
    queue_wdata = ni;
    queue_we    = 1'b0;
    unique case (cmd.op)
      mfn_pkg::DP_SWEEP_WALL: begin
        wall_waddr = sweep_cnt;
        wall_wdata = 4'd0;
        wall_we    = 1'b1;
      end
      mfn_pkg::DP_SWEEP_DIST: begin
        dist_waddr = sweep_cnt;
        dist_wdata = mfn_pkg::UNREACHED;
        dist_we    = 1'b1;
      end
      mfn_pkg::DP_WC_WR: wall_we = 1'b1;
      mfn_pkg::DP_WN_RD: wall_raddr = cur_nb[cmd.dir][AW-1:0];
      mfn_pkg::DP_WN_WR: begin
        wall_waddr = cur_nb[cmd.dir][AW-1:0];
        wall_wdata = wall_rd | (4'd1 << (cmd.dir + 2'd2));
        wall_we    = 1'b1;
      end
      mfn_pkg::DP_SEED: begin
        dist_waddr  = tgt_cell;
        dist_wdata  = '0;
        dist_we     = tgt_ok;
        queue_waddr = '0;
        queue_wdata = tgt_cell;
        queue_we    = tgt_ok;
      end
      mfn_pkg::DP_CELL_RD: begin
        wall_raddr = queue_rd;
        dist_raddr = queue_rd;
      end
      mfn_pkg::DP_NB_RD: dist_raddr = cell_nb[cmd.dir][AW-1:0];
      mfn_pkg::DP_NB_CHK: if (dist_rd == mfn_pkg::UNREACHED) begin
        dist_we  = 1'b1;
        queue_we = (int'(count) < QUEUE_DEPTH);
      end
      mfn_pkg::DP_SN_RD: dist_raddr = cur_nb[cmd.dir][AW-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
    wall_rd  <= wall_mem[wall_raddr];
    dist_rd  <= dist_mem[dist_raddr];
    queue_rd <= queue_mem[queue_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_row      <= 4'd7;
      goal_col      <= 4'd7;
      home_row      <= 4'd0;
      home_col      <= 4'd0;
      start_heading <= 2'd0;
      cur_row       <= '0;
      cur_col       <= '0;
      heading       <= mfn_pkg::DIR_N;
      sweep_cnt     <= '0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mfn_pkg::CFG_TARGET_ROW:    goal_row <= cfg_data;
          mfn_pkg::CFG_TARGET_COL:    goal_col <= cfg_data;
          mfn_pkg::CFG_START_ROW:     home_row <= cfg_data;
          mfn_pkg::CFG_START_COL:     home_col <= cfg_data;
          mfn_pkg::CFG_START_HEADING: start_heading <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == mfn_pkg::DP_DECIDE || cmd.op == mfn_pkg::DP_RESTART_OUT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        mfn_pkg::DP_SWEEP_WALL, mfn_pkg::DP_SWEEP_DIST: sweep_cnt <= sweep_cnt + 1'b1;
        mfn_pkg::DP_SEED: begin
          head  <= '0;
          tail  <= tgt_ok ? QW'(1) : '0;
          count <= tgt_ok ? CNW'(1) : '0;
        end
        mfn_pkg::DP_NB_CHK: if (dist_rd == mfn_pkg::UNREACHED &&
                                int'(count) < QUEUE_DEPTH) begin
          tail  <= (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
          count <= count + 1'b1;
        end
        mfn_pkg::DP_POP_DONE: begin
          head  <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          count <= count - 1'b1;
        end
        mfn_pkg::DP_DECIDE: begin
          heading   <= tdir;
          if (mv) begin
            cur_row <= mv_nb[AW-1:CW];
            cur_col <= mv_nb[CW-1:0];
          end
        end
        mfn_pkg::DP_RESTART_OUT: begin
          cur_row   <= srow;
          cur_col   <= scol;
          heading   <= start_heading;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mfn_pkg::DP_CAPTURE: begin
        wmask <= (in_walls[0] ? 4'd1 << heading : 4'd0)
               | (in_walls[1] ? 4'd1 << (heading + 2'd3) : 4'd0)
               | (in_walls[2] ? 4'd1 << (heading + 2'd1) : 4'd0);
      end
      mfn_pkg::DP_CELL_RD: pop_cell <= queue_rd;
      mfn_pkg::DP_CELL_LAT: begin
        nd    <= (dist_rd >= mfn_pkg::DIST_MAX) ? mfn_pkg::DIST_MAX : dist_rd + 1'b1;
        cwall <= wall_rd;
      end
      mfn_pkg::DP_NB_RD: ni <= cell_nb[cmd.dir][AW-1:0];
      mfn_pkg::DP_SEL_LAT: begin
        cdist <= dist_rd;
        best  <= dist_rd;
        cwall <= wall_rd;
        tdir  <= heading;
      end
      mfn_pkg::DP_SN_CHK: begin
        ndist[cmd.dir] <= dist_rd;
        if (cur_nb[cmd.dir][AW] && !cwall[cmd.dir] && dist_rd < best) begin
          best <= dist_rd;
          tdir <= cmd.dir;
        end
      end
      mfn_pkg::DP_DECIDE: begin
        out_turn  <= turn;
        out_moved <= mv;
        out_row   <= 4'(mv ? mv_nb[AW-1:CW] : cur_row);
        out_col   <= 4'(mv ? mv_nb[CW-1:0] : cur_col);
        out_head  <= tdir;
        out_dist  <= mv ? ndist[tdir] : cdist;
      end
      mfn_pkg::DP_RESTART_OUT: begin
        out_turn  <= mfn_pkg::TURN_NONE;
        out_moved <= 1'b0;
        out_row   <= 4'(srow);
        out_col   <= 4'(scol);
        out_head  <= start_heading;
        out_dist  <= mfn_pkg::UNREACHED;
      end
      default: begin
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_dist, out_head, out_col, out_row, out_moved, out_turn};

endmodule

>>> hw/rtl/mfn_controller.sv
// ----------------------------------------------------------------------------
// mfn_controller: sequencer of the navigator
// Steps through wall clearing and update, distance sweep, breadth-first
// fill, neighbour choice and result hand-off, one datapath command per cycle.
// ----------------------------------------------------------------------------
module mfn_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  input  mfn_pkg::status_t status,
  output logic             in_ready,
  output mfn_pkg::cmd_t    cmd
);

  localparam logic [4:0] ST_CLR     = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_WC_RD   = 5'd2;
  localparam logic [4:0] ST_WC_WR   = 5'd3;
  localparam logic [4:0] ST_WN_RD   = 5'd4;
  localparam logic [4:0] ST_WN_WR   = 5'd5;
  localparam logic [4:0] ST_FILL    = 5'd6;
  localparam logic [4:0] ST_SEED    = 5'd7;
  localparam logic [4:0] ST_POP     = 5'd8;
  localparam logic [4:0] ST_CELL    = 5'd9;
  localparam logic [4:0] ST_CLAT    = 5'd10;
  localparam logic [4:0] ST_NB_RD   = 5'd11;
  localparam logic [4:0] ST_NB_CHK  = 5'd12;
  localparam logic [4:0] ST_PDONE   = 5'd13;
  localparam logic [4:0] ST_SEL_RD  = 5'd14;
  localparam logic [4:0] ST_SEL_LAT = 5'd15;
  localparam logic [4:0] ST_SN_RD   = 5'd16;
  localparam logic [4:0] ST_SN_CHK  = 5'd17;
  localparam logic [4:0] ST_DEC     = 5'd18;
  localparam logic [4:0] ST_RST_OUT = 5'd19;

  logic [4:0] state, state_next;
  logic [1:0] k, k_next;
  logic       restart, restart_next;
  logic [1:0] sdir;

  assign sdir = mfn_pkg::scan_dir(k);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    k_next       = k;
    restart_next = restart;
    cmd.op       = mfn_pkg::DP_NOP;
    cmd.dir      = k;
    unique case (state)
      ST_CLR: begin
        cmd.op = mfn_pkg::DP_SWEEP_WALL;
        if (status.sweep_last) state_next = restart ? ST_RST_OUT : ST_IDLE;
      end
      ST_IDLE: if (in_valid) begin
        cmd.op = mfn_pkg::DP_CAPTURE;
        if (in_op == mfn_pkg::OP_RESTART) begin
          restart_next = 1'b1;
          state_next   = ST_CLR;
        end else begin
          state_next = ST_WC_RD;
        end
      end
      ST_WC_RD: begin
        cmd.op     = mfn_pkg::DP_WC_RD;
        state_next = ST_WC_WR;
      end
      ST_WC_WR: begin
        cmd.op     = mfn_pkg::DP_WC_WR;
        k_next     = 2'd0;
        state_next = ST_WN_RD;
      end
      ST_WN_RD: begin
        if (status.wmask[k] && status.cur_nb_ok[k]) begin
          cmd.op     = mfn_pkg::DP_WN_RD;
          state_next = ST_WN_WR;
        end else if (k == 2'd3) begin
          state_next = ST_FILL;
        end else begin
          k_next = k + 2'd1;
        end
      end
      ST_WN_WR: begin
        cmd.op = mfn_pkg::DP_WN_WR;
        k_next = k + 2'd1;
        state_next = (k == 2'd3) ? ST_FILL : ST_WN_RD;
      end
      ST_FILL: begin
        cmd.op = mfn_pkg::DP_SWEEP_DIST;
        if (status.sweep_last) state_next = ST_SEED;
      end
      ST_SEED: begin
        cmd.op     = mfn_pkg::DP_SEED;
        state_next = ST_POP;
      end
      ST_POP: begin
        if (status.queue_empty) begin
          state_next = ST_SEL_RD;
        end else begin
          cmd.op     = mfn_pkg::DP_POP_RD;
          state_next = ST_CELL;
        end
      end
      ST_CELL: begin
        cmd.op     = mfn_pkg::DP_CELL_RD;
        state_next = ST_CLAT;
      end
      ST_CLAT: begin
        cmd.op     = mfn_pkg::DP_CELL_LAT;
        k_next     = 2'd0;
        state_next = ST_NB_RD;
      end
      ST_NB_RD: begin
        cmd.dir = sdir;
        if (status.cell_open[sdir]) begin
          cmd.op     = mfn_pkg::DP_NB_RD;
          state_next = ST_NB_CHK;
        end else if (k == 2'd3) begin
          state_next = ST_PDONE;
        end else begin
          k_next = k + 2'd1;
        end
      end
      ST_NB_CHK: begin
        cmd.op  = mfn_pkg::DP_NB_CHK;
        cmd.dir = sdir;
        k_next  = k + 2'd1;
        state_next = (k == 2'd3) ? ST_PDONE : ST_NB_RD;
      end
      ST_PDONE: begin
        cmd.op     = mfn_pkg::DP_POP_DONE;
        state_next = ST_POP;
      end
      ST_SEL_RD: begin
        cmd.op     = mfn_pkg::DP_SEL_RD;
        state_next = ST_SEL_LAT;
      end
      ST_SEL_LAT: begin
        cmd.op     = mfn_pkg::DP_SEL_LAT;
        k_next     = 2'd0;
        state_next = ST_SN_RD;
      end
      ST_SN_RD: begin
        cmd.op     = mfn_pkg::DP_SN_RD;
        cmd.dir    = sdir;
        state_next = ST_SN_CHK;
      end
      ST_SN_CHK: begin
        cmd.op  = mfn_pkg::DP_SN_CHK;
        cmd.dir = sdir;
        k_next  = k + 2'd1;
        state_next = (k == 2'd3) ? ST_DEC : ST_SN_RD;
      end
      ST_DEC: if (status.out_free) begin
        cmd.op     = mfn_pkg::DP_DECIDE;
        state_next = ST_IDLE;
      end
      ST_RST_OUT: if (status.out_free) begin
        cmd.op       = mfn_pkg::DP_RESTART_OUT;
        restart_next = 1'b0;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      k       <= 2'd0;
      restart <= 1'b0;
    end else begin
      state   <= state_next;
      k       <= k_next;
      restart <= restart_next;
    end
  end

endmodule

>>> hw/rtl/maze_floodfill_navigator_core.sv
// ----------------------------------------------------------------------------
// maze_floodfill_navigator_core: grid maze navigator with flood fill
// Records sensed walls, reruns a breadth-first fill from the goal cell and
// turns and steps toward the closest open neighbour.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                carries
//  s_*       in         s_tvalid / s_tready      one sense or restart request
//  m_*       out        m_tvalid / m_tready      one navigation result
//  cfg_*     in         cfg_valid / cfg_ready    register index and value
//
//  A step request runs the sequential fill on the distance memory, which has
//  one read port and one write port, after the sensed walls are recorded.
//  A restart request runs the wall clearing pass.
//  After reset the same clearing pass runs before s_tready.
//  The result register holds a result while m_tready is low; the next
//  request is taken meanwhile and its own result waits for the register.
// ----------------------------------------------------------------------------
module maze_floodfill_navigator_core #(
  parameter int ROWS = 16,
  parameter int COLS = 16,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mfn_pkg::IN_DATA_W-1:0]  s_tdata,   // wall_front, wall_left, wall_right
  input  logic                           s_tuser,   // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mfn_pkg::OUT_DATA_W-1:0] m_tdata,   // turn_cmd, moved, pos_row, pos_col,
                                                    // new_heading, cell_distance
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfn_pkg::CFG_DATA_W-1:0] cfg_data
);

  mfn_pkg::cmd_t    cmd;
  mfn_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mfn_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  mfn_datapath #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_walls  (s_tdata[2:0]),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  a_move_closer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[21:13] != mfn_pkg::UNREACHED)
    else $error("move into an unreached cell");

  a_result_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mfn_pkg::DP_DECIDE || cmd.op == mfn_pkg::DP_RESTART_OUT)
      |-> (!m_tvalid || m_tready))
    else $error("result overwritten before delivery");
`endif

endmodule
